FILE: hw/rtl/emergency_error_manager_macros.svh
// Assertion helpers used by the RTL files that include this header (eem_ctrl).
`ifndef EMERGENCY_ERROR_MANAGER_MACROS_SVH
`define EMERGENCY_ERROR_MANAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EEM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/eem_pkg.sv
`timescale 1ns / 1ps

package eem_pkg;

    // Default sizes
    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int HIST_DEPTH_DEF    = 8;

    // Request function codes
    localparam logic [1:0] FUNC_RAISE   = 2'd0;
    localparam logic [1:0] FUNC_RECOVER = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;
    localparam logic [1:0] FUNC_READ    = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_DONE       = 2'd0;
    localparam logic [1:0] STAT_ACTIVE     = 2'd1;
    localparam logic [1:0] STAT_FULL       = 2'd2;
    localparam logic [1:0] STAT_NOT_ACTIVE = 2'd3;

    // Configuration register indexes (word address)
    localparam logic [1:0] CFG_IDX_ENABLE = 2'd0;
    localparam logic [1:0] CFG_IDX_COB_ID = 2'd1;
    localparam logic [1:0] CFG_IDX_HSIZE  = 2'd2;

    // Configuration reset values
    localparam logic        CFG_ENABLE_RST = 1'b0;
    localparam logic [10:0] CFG_COB_ID_RST = 11'd128;
    localparam logic [3:0]  CFG_HSIZE_RST  = 4'd8;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY,
        ST_REPORT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic search;
        logic apply;
        logic report;
    } t_dp_cmd;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic        emcy_enabled;
        logic [10:0] emcy_cob_id;
        logic [3:0]  history_size;
    } t_cfg;

endpackage

FILE: hw/rtl/emergency_error_manager.sv
`timescale 1ns / 1ps
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+------------------------------------------
// request   | start high while busy low        | i_func, i_err_code, i_reg_mask,
//           |                                  | i_add_info, i_hist_index
// result    | o_done, one cycle                | o_status .. o_read_data
// config    | psel & penable & pwrite (pready) | paddr[3:2] selects register, pwdata
//
// A request passes through capture, table search, apply and report; the result
// strobe rises with busy falling, so a new request may be accepted in that cycle.
// Reset is synchronous, active low; it clears the table, history and configuration.
// The result receiver cannot stall; each result strobe is shown for one cycle only.

module emergency_error_manager #(
    parameter int TABLE_ENTRIES = eem_pkg::TABLE_ENTRIES_DEF,
    parameter int HIST_DEPTH    = eem_pkg::HIST_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_err_code,
    input  logic [7:0]  i_reg_mask,
    input  logic [15:0] i_add_info,
    input  logic [2:0]  i_hist_index,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_err_reg,
    output logic        o_fault_free,
    output logic [3:0]  o_history_count,
    output logic        o_frame_valid,
    output logic [10:0] o_frame_cob_id,
    output logic [15:0] o_frame_err_code,
    output logic [7:0]  o_frame_err_reg,
    output logic [15:0] o_frame_info,
    output logic [31:0] o_read_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    eem_pkg::t_cfg    w_cfg;
    eem_pkg::t_dp_cmd w_cmd;

    // Configuration registers
    eem_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer
    eem_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // Table, history and result registers
    eem_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HIST_DEPTH    (HIST_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg            (w_cfg),
        .i_func           (i_func),
        .i_err_code       (i_err_code),
        .i_reg_mask       (i_reg_mask),
        .i_add_info       (i_add_info),
        .i_hist_index     (i_hist_index),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_err_reg        (o_err_reg),
        .o_fault_free     (o_fault_free),
        .o_history_count  (o_history_count),
        .o_frame_valid    (o_frame_valid),
        .o_frame_cob_id   (o_frame_cob_id),
        .o_frame_err_code (o_frame_err_code),
        .o_frame_err_reg  (o_frame_err_reg),
        .o_frame_info     (o_frame_info),
        .o_read_data      (o_read_data)
    );

endmodule

FILE: hw/rtl/eem_cfg.sv
`timescale 1ns / 1ps

module eem_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output eem_pkg::t_cfg  o_cfg
);

    logic        r_emcy_enabled;
    logic [10:0] r_emcy_cob_id;
    logic [3:0]  r_history_size;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    // Register writes; unmapped addresses are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emcy_enabled <= eem_pkg::CFG_ENABLE_RST;
            r_emcy_cob_id  <= eem_pkg::CFG_COB_ID_RST;
            r_history_size <= eem_pkg::CFG_HSIZE_RST;
        end else if (w_wr) begin
            if (w_idx == eem_pkg::CFG_IDX_ENABLE) r_emcy_enabled <= pwdata[0];
            if (w_idx == eem_pkg::CFG_IDX_COB_ID) r_emcy_cob_id  <= pwdata[10:0];
            if (w_idx == eem_pkg::CFG_IDX_HSIZE)  r_history_size <= pwdata[3:0];
        end
    end

    // Read mux
    always_comb begin
        prdata = 32'd0;
        unique case (w_idx)
            eem_pkg::CFG_IDX_ENABLE: prdata = {31'd0, r_emcy_enabled};
            eem_pkg::CFG_IDX_COB_ID: prdata = {21'd0, r_emcy_cob_id};
            eem_pkg::CFG_IDX_HSIZE:  prdata = {28'd0, r_history_size};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg.emcy_enabled = r_emcy_enabled;
    assign o_cfg.emcy_cob_id  = r_emcy_cob_id;
    assign o_cfg.history_size = r_history_size;

endmodule

FILE: hw/rtl/eem_ctrl.sv
`timescale 1ns / 1ps
`include "emergency_error_manager_macros.svh"

module eem_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output eem_pkg::t_dp_cmd  o_cmd
);

    eem_pkg::t_state r_state;
    eem_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eem_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.search  = 1'b0;
        o_cmd.apply   = 1'b0;
        o_cmd.report  = 1'b0;
        unique case (r_state)
            eem_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = eem_pkg::ST_SEARCH;
                end
            end
            eem_pkg::ST_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state      = eem_pkg::ST_APPLY;
            end
            eem_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = eem_pkg::ST_REPORT;
            end
            eem_pkg::ST_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = eem_pkg::ST_IDLE;
            end
            default: n_state = eem_pkg::ST_IDLE;
        endcase
    end

    assign busy = (r_state != eem_pkg::ST_IDLE);

    // Checks
    `EEM_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, start && !busy, r_state == eem_pkg::ST_SEARCH)
    `EEM_ASSERT_NEXT(a_report_ends, i_clk, i_rst_n, o_cmd.report, !busy)
    `EEM_ASSERT_IMPL(a_busy_falls_after_report, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), $past(r_state == eem_pkg::ST_REPORT))
    `EEM_ASSERT_IMPL(a_cmd_onehot, i_clk, i_rst_n, busy || start, $onehot(o_cmd))

endmodule

FILE: hw/rtl/eem_datapath.sv
`timescale 1ns / 1ps

module eem_datapath #(
    parameter int TABLE_ENTRIES = eem_pkg::TABLE_ENTRIES_DEF,
    parameter int HIST_DEPTH    = eem_pkg::HIST_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  eem_pkg::t_dp_cmd  i_cmd,
    input  eem_pkg::t_cfg     i_cfg,
    input  logic [1:0]        i_func,
    input  logic [15:0]       i_err_code,
    input  logic [7:0]        i_reg_mask,
    input  logic [15:0]       i_add_info,
    input  logic [2:0]        i_hist_index,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [7:0]        o_err_reg,
    output logic              o_fault_free,
    output logic [3:0]        o_history_count,
    output logic              o_frame_valid,
    output logic [10:0]       o_frame_cob_id,
    output logic [15:0]       o_frame_err_code,
    output logic [7:0]        o_frame_err_reg,
    output logic [15:0]       o_frame_info,
    output logic [31:0]       o_read_data
);

    // The 4-bit size register never selects more than 15 words
    localparam int HIST_WORDS = (HIST_DEPTH < 15) ? HIST_DEPTH : 15;

    // Captured request
    logic [1:0]  r_func;
    logic [15:0] r_code;
    logic [7:0]  r_mask;
    logic [15:0] r_info;
    logic [2:0]  r_hidx;

    // Error table and history
    logic [15:0]              r_tab_code [TABLE_ENTRIES];
    logic [7:0]               r_tab_mask [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_active;
    logic [31:0]              r_hist [HIST_WORDS];
    logic [3:0]               r_hist_cnt;

    // Search results and apply outcome
    logic [TABLE_ENTRIES-1:0] r_match_oh;
    logic [TABLE_ENTRIES-1:0] r_free_oh;
    logic                     r_wrote;
    logic                     r_cleared;
    logic [1:0]               r_status;

    // Result registers
    logic        r_done;
    logic [1:0]  r_o_status;
    logic [7:0]  r_o_err_reg;
    logic        r_o_err_free;
    logic [3:0]  r_o_hist_cnt;
    logic        r_o_fvalid;
    logic [10:0] r_o_cob_id;
    logic [15:0] r_o_fcode;
    logic [7:0]  r_o_freg;
    logic [15:0] r_o_finfo;
    logic [31:0] r_o_rdata;

    logic [TABLE_ENTRIES-1:0] w_match;
    logic [TABLE_ENTRIES-1:0] w_inact;
    logic [TABLE_ENTRIES-1:0] w_pos;
    logic                     w_match_any;
    logic                     w_match_act;
    logic                     w_pos_any;
    logic                     w_raise_ok;
    logic                     w_recover_ok;
    logic [3:0]               w_size;
    logic [7:0]               w_mask_or;
    logic                     w_any_active;
    logic [31:0]              w_rdata;
    logic                     w_fvalid;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_code <= i_err_code;
            r_mask <= i_reg_mask;
            r_info <= i_add_info;
            r_hidx <= i_hist_index;
        end
    end

    // Parallel code compare
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_match[i] = (r_tab_code[i] == r_code);
        end
    end
    assign w_inact = ~r_active;

    // Keep only the lowest set bit of each vector
    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_match_oh <= w_match & (~w_match + TABLE_ENTRIES'(1));
            r_free_oh  <= w_inact & (~w_inact + TABLE_ENTRIES'(1));
        end
    end

    // Apply decisions
    assign w_match_any  = |r_match_oh;
    assign w_match_act  = |(r_match_oh & r_active);
    assign w_pos        = w_match_any ? r_match_oh : r_free_oh;
    assign w_pos_any    = |w_pos;
    assign w_raise_ok   = (r_func == eem_pkg::FUNC_RAISE) && !w_match_act && w_pos_any;
    assign w_recover_ok = (r_func == eem_pkg::FUNC_RECOVER) && w_match_act;

    // Effective history size: zero counts as one, clamp to depth
    always_comb begin
        w_size = i_cfg.history_size;
        if (w_size == 4'd0) begin
            w_size = 4'd1;
        end else if (int'(w_size) > HIST_DEPTH) begin
            w_size = 4'(HIST_DEPTH);
        end
    end

    // Table and history update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_tab_code[i] <= 16'd0;
                r_tab_mask[i] <= 8'd0;
            end
            r_active <= '0;
            for (int i = 0; i < HIST_WORDS; i++) begin
                r_hist[i] <= 32'd0;
            end
            r_hist_cnt <= 4'd0;
        end else if (i_cmd.apply) begin
            unique case (r_func)
                eem_pkg::FUNC_RAISE: begin
                    if (w_raise_ok) begin
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            if (w_pos[i]) begin
                                r_tab_code[i] <= r_code;
                                r_tab_mask[i] <= r_mask;
                                r_active[i]   <= 1'b1;
                            end
                        end
                        for (int i = 1; i < HIST_WORDS; i++) begin
                            if (i < int'(w_size)) r_hist[i] <= r_hist[i-1];
                        end
                        r_hist[0] <= {r_info, r_code};
                        if (r_hist_cnt < w_size) r_hist_cnt <= r_hist_cnt + 4'd1;
                    end
                end
                eem_pkg::FUNC_RECOVER: begin
                    if (w_recover_ok) r_active <= r_active & ~r_match_oh;
                end
                eem_pkg::FUNC_CLEAR: begin
                    r_hist_cnt <= 4'd0;
                    for (int i = 0; i < HIST_WORDS; i++) begin
                        if (i < int'(w_size)) r_hist[i] <= 32'd0;
                    end
                end
                eem_pkg::FUNC_READ: begin
                end
            endcase
        end
    end

    // Apply outcome for the report step
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_wrote   <= w_raise_ok;
            r_cleared <= w_recover_ok;
            if (r_func == eem_pkg::FUNC_RAISE && w_match_act) begin
                r_status <= eem_pkg::STAT_ACTIVE;
            end else if (r_func == eem_pkg::FUNC_RAISE && !w_pos_any) begin
                r_status <= eem_pkg::STAT_FULL;
            end else if (r_func == eem_pkg::FUNC_RECOVER && !w_match_act) begin
                r_status <= eem_pkg::STAT_NOT_ACTIVE;
            end else begin
                r_status <= eem_pkg::STAT_DONE;
            end
        end
    end

    // Error register: OR of masks of active entries
    always_comb begin
        w_mask_or = 8'd0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (r_active[i]) w_mask_or = w_mask_or | r_tab_mask[i];
        end
    end
    assign w_any_active = |r_active;

    // History read; indexes past the depth read zero
    always_comb begin
        w_rdata = 32'd0;
        for (int i = 0; i < HIST_WORDS; i++) begin
            if (int'(r_hidx) == i) w_rdata = r_hist[i];
        end
    end

    assign w_fvalid = i_cfg.emcy_enabled & (r_wrote | (r_cleared & ~w_any_active));

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.report;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_o_status   <= r_status;
            r_o_err_reg  <= w_mask_or;
            r_o_err_free <= ~w_any_active;
            r_o_hist_cnt <= r_hist_cnt;
            r_o_fvalid   <= w_fvalid;
            r_o_cob_id   <= w_fvalid ? i_cfg.emcy_cob_id : 11'd0;
            r_o_fcode    <= (w_fvalid && r_wrote) ? r_code : 16'd0;
            r_o_freg     <= (w_fvalid && r_wrote) ? w_mask_or : 8'd0;
            r_o_finfo    <= (w_fvalid && r_cleared) ? r_code : 16'd0;
            r_o_rdata    <= (r_func == eem_pkg::FUNC_READ) ? w_rdata : 32'd0;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_o_status;
    assign o_err_reg        = r_o_err_reg;
    assign o_fault_free     = r_o_err_free;
    assign o_history_count  = r_o_hist_cnt;
    assign o_frame_valid    = r_o_fvalid;
    assign o_frame_cob_id   = r_o_cob_id;
    assign o_frame_err_code = r_o_fcode;
    assign o_frame_err_reg  = r_o_freg;
    assign o_frame_info     = r_o_finfo;
    assign o_read_data      = r_o_rdata;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NUM_ENTRIES = eem_pkg::TABLE_ENTRIES_DEF;
    localparam int NUM_HIST    = eem_pkg::HIST_DEPTH_DEF;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 80;
    localparam int POOL_SIZE   = 12;
    localparam int IDLE_PCT    = 23;
    localparam int QUIET_LIMIT = 1000;

    // One request as driven on the ports
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] code;
        logic [7:0]  mask;
        logic [15:0] info;
        logic [2:0]  hidx;
    } emcy_request_t;

    localparam int REQ_BITS = $bits(emcy_request_t);

    // One result as seen on the ports
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  err_reg;
        logic        err_free;
        logic [3:0]  hist_count;
        logic        frame_valid;
        logic [10:0] frame_cob;
        logic [15:0] frame_code;
        logic [7:0]  frame_reg;
        logic [15:0] frame_info;
        logic [31:0] read_data;
    } emcy_result_t;

    // Tracks error table, history and frames; holds expected results in order
    class emcy_tracker;
        logic        cfg_enable;
        logic [10:0] cfg_cob_id;
        logic [3:0]  cfg_hist_size;
        logic [15:0] code_tab[NUM_ENTRIES];
        logic [7:0]  mask_tab[NUM_ENTRIES];
        logic        active_tab[NUM_ENTRIES];
        logic [31:0] hist_tab[NUM_HIST];
        logic [3:0]  hist_count;
        logic        free_state;
        logic [7:0]  err_reg;
        emcy_result_t pending_results[$];
        int errors;

        function new();
            cfg_enable    = eem_pkg::CFG_ENABLE_RST;
            cfg_cob_id    = eem_pkg::CFG_COB_ID_RST;
            cfg_hist_size = eem_pkg::CFG_HSIZE_RST;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                code_tab[i]   = '0;
                mask_tab[i]   = '0;
                active_tab[i] = 1'b0;
            end
            for (int i = 0; i < NUM_HIST; i++) hist_tab[i] = '0;
            hist_count = '0;
            free_state = 1'b1;
            err_reg    = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                eem_pkg::CFG_IDX_ENABLE: cfg_enable    = val[0];
                eem_pkg::CFG_IDX_COB_ID: cfg_cob_id    = val[10:0];
                eem_pkg::CFG_IDX_HSIZE:  cfg_hist_size = val[3:0];
                default: ;
            endcase
        endfunction

        // size 0 acts as 1, anything past the depth is clipped
        function int hist_span();
            if (int'(cfg_hist_size) == 0) return 1;
            if (int'(cfg_hist_size) > NUM_HIST) return NUM_HIST;
            return int'(cfg_hist_size);
        endfunction

        function int find_code(logic [15:0] code);
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (code_tab[i] == code) return i;
            return -1;
        endfunction

        function int find_free();
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (!active_tab[i]) return i;
            return -1;
        endfunction

        function bit any_active();
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (active_tab[i]) return 1'b1;
            return 1'b0;
        endfunction

        function logic [7:0] active_mask_or();
            logic [7:0] m;
            m = '0;
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (active_tab[i]) m |= mask_tab[i];
            return m;
        endfunction

        // Apply one accepted request and queue the result it must produce
        function void note_request(emcy_request_t rq);
            emcy_result_t r;
            int pos;
            int span;
            r    = '0;
            span = hist_span();
            case (rq.func)
                eem_pkg::FUNC_RAISE: begin
                    pos = find_code(rq.code);
                    if (pos >= 0 && active_tab[pos]) begin
                        r.status = eem_pkg::STAT_ACTIVE;
                    end else begin
                        if (pos < 0) pos = find_free();
                        if (pos < 0) begin
                            r.status = eem_pkg::STAT_FULL;
                        end else begin
                            code_tab[pos]   = rq.code;
                            mask_tab[pos]   = rq.mask;
                            active_tab[pos] = 1'b1;
                            free_state      = 1'b0;
                            err_reg         = active_mask_or();
                            for (int i = span - 1; i > 0; i--) hist_tab[i] = hist_tab[i - 1];
                            hist_tab[0] = {rq.info, rq.code};
                            if (int'(hist_count) < span) hist_count++;
                            if (cfg_enable) begin
                                r.frame_valid = 1'b1;
                                r.frame_cob   = cfg_cob_id;
                                r.frame_code  = rq.code;
                                r.frame_reg   = err_reg;
                            end
                        end
                    end
                end
                eem_pkg::FUNC_RECOVER: begin
                    pos = find_code(rq.code);
                    if (pos >= 0 && active_tab[pos]) begin
                        active_tab[pos] = 1'b0;
                        err_reg = active_mask_or();
                        // last active error gone: back to error free
                        if (!any_active()) begin
                            free_state = 1'b1;
                            if (cfg_enable) begin
                                r.frame_valid = 1'b1;
                                r.frame_cob   = cfg_cob_id;
                                r.frame_info  = rq.code;
                            end
                        end
                    end else begin
                        r.status = eem_pkg::STAT_NOT_ACTIVE;
                    end
                end
                eem_pkg::FUNC_CLEAR: begin
                    hist_count = '0;
                    for (int i = 0; i < span; i++) hist_tab[i] = '0;
                end
                default: begin
                    if (int'(rq.hidx) < NUM_HIST) r.read_data = hist_tab[rq.hidx];
                end
            endcase
            r.err_reg    = err_reg;
            r.err_free   = free_state;
            r.hist_count = hist_count;
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(emcy_result_t got);
            emcy_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("err_reg", 32'(want.err_reg), 32'(got.err_reg));
            check_field("fault_free", 32'(want.err_free), 32'(got.err_free));
            check_field("history_count", 32'(want.hist_count), 32'(got.hist_count));
            check_field("frame_valid", 32'(want.frame_valid), 32'(got.frame_valid));
            check_field("frame_cob_id", 32'(want.frame_cob), 32'(got.frame_cob));
            check_field("frame_err_code", 32'(want.frame_code), 32'(got.frame_code));
            check_field("frame_err_reg", 32'(want.frame_reg), 32'(got.frame_reg));
            check_field("frame_info", 32'(want.frame_info), 32'(got.frame_info));
            check_field("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [15:0] i_err_code;
    logic [7:0]  i_reg_mask;
    logic [15:0] i_add_info;
    logic [2:0]  i_hist_index;
    logic        o_done;
    logic [1:0]  o_status;
    logic [7:0]  o_err_reg;
    logic        o_fault_free;
    logic [3:0]  o_history_count;
    logic        o_frame_valid;
    logic [10:0] o_frame_cob_id;
    logic [15:0] o_frame_err_code;
    logic [7:0]  o_frame_err_reg;
    logic [15:0] o_frame_info;
    logic [31:0] o_read_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    emcy_tracker tracker;
    logic [15:0] code_pool[POOL_SIZE];
    bit          idle_on;
    int          quiet_cycles;

    emergency_error_manager uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_err_code       (i_err_code),
        .i_reg_mask       (i_reg_mask),
        .i_add_info       (i_add_info),
        .i_hist_index     (i_hist_index),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_err_reg        (o_err_reg),
        .o_fault_free     (o_fault_free),
        .o_history_count  (o_history_count),
        .o_frame_valid    (o_frame_valid),
        .o_frame_cob_id   (o_frame_cob_id),
        .o_frame_err_code (o_frame_err_code),
        .o_frame_err_reg  (o_frame_err_reg),
        .o_frame_info     (o_frame_info),
        .o_read_data      (o_read_data),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Request accepted: update predictor
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            tracker.note_request({i_func, i_err_code, i_reg_mask, i_add_info, i_hist_index});
    end

    // Result strobe: compare against oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tracker.check_result({o_status, o_err_reg, o_fault_free, o_history_count,
                                  o_frame_valid, o_frame_cob_id, o_frame_err_code,
                                  o_frame_err_reg, o_frame_info, o_read_data});
    end

    // Watchdog: cycles with no request, result or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    function automatic emcy_request_t mk_req(logic [1:0] func, logic [15:0] code,
                                             logic [7:0] mask, logic [15:0] info,
                                             logic [2:0] hidx);
        return {func, code, mask, info, hidx};
    endfunction

    // Random request, mostly codes from the pool so raises and recovers meet
    function automatic emcy_request_t random_req();
        emcy_request_t rq;
        int pick;
        rq   = REQ_BITS'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 42)      rq.func = eem_pkg::FUNC_RAISE;
        else if (pick < 84) rq.func = eem_pkg::FUNC_RECOVER;
        else if (pick < 89) rq.func = eem_pkg::FUNC_CLEAR;
        else                rq.func = eem_pkg::FUNC_READ;
        if ($urandom_range(9) != 0) rq.code = code_pool[$urandom_range(POOL_SIZE - 1)];
        return rq;
    endfunction

    // Random idle cycles ahead of a request
    task automatic idle_gap();
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            start        = 1'b0;
            i_func       = 2'($urandom);
            i_err_code   = 16'($urandom);
            i_reg_mask   = 8'($urandom);
            i_add_info   = 16'($urandom);
            i_hist_index = 3'($urandom);
        end
    endtask

    task automatic send_request(emcy_request_t rq);
        idle_gap();
        @(negedge i_clk);
        start        = 1'b1;
        i_func       = rq.func;
        i_err_code   = rq.code;
        i_reg_mask   = rq.mask;
        i_add_info   = rq.info;
        i_hist_index = rq.hidx;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Let the block go idle, then write all three registers
    task automatic program_regs(logic en, logic [10:0] cob, logic [3:0] hsize);
        @(negedge i_clk);
        start = 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        apb_write(eem_pkg::CFG_IDX_ENABLE, {31'd0, en});
        apb_write(eem_pkg::CFG_IDX_COB_ID, {21'd0, cob});
        apb_write(eem_pkg::CFG_IDX_HSIZE, {28'd0, hsize});
    endtask

    task automatic run_directed();
        // fresh history reads zero; default config has frames off
        send_request(mk_req(eem_pkg::FUNC_READ, 16'h0000, 8'h00, 16'h0000, 3'd0));
        program_regs(1'b1, 11'h7FF, 4'd8);
        // reset entries hold code 0 but are inactive
        send_request(mk_req(eem_pkg::FUNC_RECOVER, 16'h0000, 8'h00, 16'h0000, 3'd0));
        send_request(mk_req(eem_pkg::FUNC_RAISE, 16'h0000, 8'h01, 16'h0000, 3'd0));
        send_request(mk_req(eem_pkg::FUNC_RAISE, 16'h0000, 8'h02, 16'h1234, 3'd0));
        send_request(mk_req(eem_pkg::FUNC_RECOVER, 16'h0000, 8'h00, 16'h0000, 3'd0));
        send_request(mk_req(eem_pkg::FUNC_RAISE, 16'hFFFF, 8'hFF, 16'hFFFF, 3'd7));
        send_request(mk_req(eem_pkg::FUNC_RECOVER, 16'hFFFF, 8'hFF, 16'hFFFF, 3'd7));
        // fill the table, then one more raise finds it full
        for (int i = 0; i < NUM_ENTRIES; i++)
            send_request(mk_req(eem_pkg::FUNC_RAISE, 16'h1000 + 16'(i), 8'h01 << i,
                                16'hA500 + 16'(i), 3'd0));
        send_request(mk_req(eem_pkg::FUNC_RAISE, 16'h2000, 8'h80, 16'h0000, 3'd0));
        send_request(mk_req(eem_pkg::FUNC_READ, 16'h0000, 8'h00, 16'h0000, 3'd0));
        send_request(mk_req(eem_pkg::FUNC_READ, 16'h0000, 8'h00, 16'h0000, 3'd7));
        send_request(mk_req(eem_pkg::FUNC_RECOVER, 16'h4321, 8'h00, 16'h0000, 3'd0));
        send_request(mk_req(eem_pkg::FUNC_CLEAR, 16'h0000, 8'h00, 16'h0000, 3'd0));
        send_request(mk_req(eem_pkg::FUNC_READ, 16'h0000, 8'h00, 16'h0000, 3'd3));
    endtask

    task automatic run_phase(int phase);
        case (phase)
            0: program_regs(1'b1, 11'h7FF, 4'd8);
            1: program_regs(1'b0, 11'h000, 4'd1);
            2: program_regs(1'b1, 11'h000, 4'd0);
            3: program_regs(1'b1, 11'h555, 4'd15);
            4: program_regs(1'b1, 11'($urandom), 4'd3);
            default: program_regs(1'b1, 11'($urandom), 4'd8);
        endcase
        code_pool[0] = 16'h0000;
        code_pool[1] = 16'hFFFF;
        for (int k = 2; k < POOL_SIZE; k++) code_pool[k] = 16'($urandom);
        // one phase runs back to back with no idle cycles
        idle_on = (phase != 3);
        for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_req());
    endtask

    initial begin
        tracker      = new();
        idle_on      = 1'b1;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_func       = '0;
        i_err_code   = '0;
        i_reg_mask   = '0;
        i_add_info   = '0;
        i_hist_index = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        for (int p = 0; p < NUM_PHASES; p++) run_phase(p);

        // drain remaining results
        @(negedge i_clk);
        start = 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/eem_pkg.sv
hw/rtl/eem_cfg.sv
hw/rtl/eem_ctrl.sv
hw/rtl/eem_datapath.sv
hw/rtl/emergency_error_manager.sv
dv/tb.sv
